// ===== design/pscs_pkg.sv =====
package pscs_pkg;

    localparam int GRID_SIDE = 1024;
    localparam int GRID_AW   = $clog2(GRID_SIDE);
    localparam int MAX_PATHS = 128;
    localparam int PC_W      = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

    localparam int MUL_W = 34;

    localparam logic [19:0] COST_MAX  = 20'hFFFFF;
    localparam logic [31:0] LEN_MAX   = 32'hFFFF_FFFF;
    localparam logic [11:0] SEG_MAX   = 12'd3825;
    localparam logic [11:0] FLOOR_RST = 12'd2040;

    localparam logic [2:0] REG_ROBOT_X = 3'd0;
    localparam logic [2:0] REG_ROBOT_Y = 3'd1;
    localparam logic [2:0] REG_ROT_COS = 3'd2;
    localparam logic [2:0] REG_ROT_SIN = 3'd3;
    localparam logic [2:0] REG_CPM     = 3'd4;
    localparam logic [2:0] REG_ORG_ROW = 3'd5;
    localparam logic [2:0] REG_ORG_COL = 3'd6;
    localparam logic [2:0] REG_SAMPLES = 3'd7;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } t_sqrt_stat;

endpackage

// ===== design/pscs_mult.sv =====
module pscs_mult (
    input  logic                                  i_clk,
    input  logic signed [pscs_pkg::MUL_W-1:0]     i_a,
    input  logic signed [pscs_pkg::MUL_W-1:0]     i_b,
    output logic signed [2*pscs_pkg::MUL_W-1:0]   o_p
);

    logic signed [2*pscs_pkg::MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== design/pscs_isqrt.sv =====
module pscs_isqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [63:0]            i_value,
    output pscs_pkg::t_sqrt_stat   o_stat
);

    logic        r_busy, r_done;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_val;
    logic [4:0]  r_cnt;

    logic [34:0] w_rem2, w_trial;

    assign w_rem2  = {r_rem[32:0], r_val[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= i_value;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_rem2 >= w_trial) begin
                    r_rem  <= w_rem2 - w_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_val <= {r_val[61:0], 2'b00};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done, root: r_root};

endmodule

// ===== design/pscs_grid.sv =====
module pscs_grid (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [2*pscs_pkg::GRID_AW-1:0]    i_waddr,
    input  logic [7:0]                        i_wdata,
    input  logic [2*pscs_pkg::GRID_AW-1:0]    i_raddr,
    output logic [7:0]                        o_rdata
);

    logic [7:0] r_mem [0:(2**(2*pscs_pkg::GRID_AW))-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/path_set_cost_scorer.sv =====
// Channel   Dir  Handshake                    Payload
// request   in   i_in_valid / o_in_ready      i_operation .. i_batch_last
// result    out  o_out_valid / i_out_ready    o_path_index .. o_batch_done
// config    in   i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// Cell write: stored in the grid when accepted. Path point: the accepting cycle, then rotation
// (a last point that is not also first skips it); a segment adds the divider and the sample
// loop (both skipped for zero samples), then the length (the squares, then the 32-step square
// root unless the sum overflows). All products use one shared 34x34 multiplier. Synchronous
// active-low reset; the grid store is not cleared. A finished path waits for the result
// register to empty or be taken; ready is low while a point is being worked on.
module path_set_cost_scorer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [9:0]         i_cell_row,
    input  logic [9:0]         i_cell_col,
    input  logic [7:0]         i_cell_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_path_first,
    input  logic               i_path_last,
    input  logic               i_batch_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_path_index,
    output logic [19:0]        o_path_cost,
    output logic [31:0]        o_path_length,
    output logic [6:0]         o_best_index,
    output logic [19:0]        o_best_cost,
    output logic [31:0]        o_best_length,
    output logic               o_batch_done,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = pscs_pkg::GRID_AW;
    localparam int MW = pscs_pkg::MUL_W;
    localparam int PW = pscs_pkg::PC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ROT, S_DIV, S_SAMP, S_LEN, S_SQRT, S_FIN
    } t_state;

    t_state r_state;
    logic [2:0] r_step;
    logic [5:0] r_cnt;

    logic signed [31:0] r_robot_x, r_robot_y;
    logic signed [15:0] r_cos, r_sin;
    logic [23:0]        r_cpm;
    logic [10:0]        r_orow, r_ocol;
    logic [3:0]         r_nsamp;

    logic               r_first, r_last, r_batch;
    logic signed [31:0] r_px, r_py;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_cx, r_cy, r_prev_x, r_prev_y;
    logic signed [32:0] r_dx, r_dy;
    logic [32:0]        r_mx, r_my;
    logic [3:0]         r_remx, r_remy;
    logic [32:0]        r_sqx, r_sqy;
    logic [3:0]         r_srx, r_sry;
    logic [3:0]         r_k;
    logic signed [31:0] r_sx, r_sy;
    logic [AW-1:0]      r_row, r_col;
    logic               r_row_ok, r_cell_ok;
    logic [7:0]         r_run_min;
    logic [11:0]        r_seg, r_floor;
    logic [19:0]        r_cost;
    logic [31:0]        r_len;
    logic [64:0]        r_sq;
    logic [PW-1:0]      r_counter;
    logic [19:0]        r_best_cost;
    logic [31:0]        r_best_len;
    logic [PW-1:0]      r_best_idx;
    logic               r_best_valid;
    logic               r_sqrt_start;

    logic               r_o_valid;
    logic [6:0]         r_o_idx, r_o_bidx;
    logic [19:0]        r_o_cost, r_o_bcost;
    logic [31:0]        r_o_len, r_o_blen;
    logic               r_o_done;

    logic signed [MW-1:0]   w_ma, w_mb;
    logic signed [2*MW-1:0] w_p;
    logic signed [32:0]     w_tx, w_ty;
    logic signed [49:0]     w_rsum;
    logic signed [35:0]     w_rsh;
    logic signed [31:0]     w_rsat;
    logic signed [59:0]     w_cv;
    logic [59:0]            w_cmag;
    logic [27:0]            w_chi;
    logic                   w_cok;
    logic [AW-1:0]          w_cidx;
    logic [31:0]            w_adx, w_ady;
    logic [4:0]             w_rdx, w_rdy;
    logic [33:0]            w_nqx, w_nqy;
    logic [4:0]             w_nrx, w_nry;
    logic [7:0]             w_cell;
    logic [7:0]             w_min;
    logic [11:0]            w_nfloor;
    logic [20:0]            w_csum;
    logic [31:0]            w_seglen;
    logic [32:0]            w_lsum;
    logic                   w_upd;
    logic                   w_in_acc;
    logic                   w_gwe;
    pscs_pkg::t_sqrt_stat   w_sqrt;
    logic [7:0]             w_rdata;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign w_tx = 33'(r_px) - 33'(r_robot_x);
    assign w_ty = 33'(r_py) - 33'(r_robot_y);
    assign w_adx = r_dx[32] ? 32'(-r_dx) : r_dx[31:0];
    assign w_ady = r_dy[32] ? 32'(-r_dy) : r_dy[31:0];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_ROT: begin
                w_ma = MW'(((r_step == 3'd0) || (r_step == 3'd2)) ? w_tx : w_ty);
                w_mb = MW'(((r_step == 3'd0) || (r_step == 3'd3)) ? r_cos : r_sin);
            end
            S_SAMP: begin
                w_ma = MW'((r_step == 3'd2) ? r_sx : r_sy);
                w_mb = MW'({1'b0, r_cpm});
            end
            S_LEN: begin
                w_ma = MW'({1'b0, (r_step == 3'd0) ? w_adx : w_ady});
                w_mb = w_ma;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    pscs_mult u_mult (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));

    // rotation: floor shift by 14 and saturation to 32 bits
    assign w_rsum = (r_step == 3'd2) ? (r_acc - w_p[49:0]) : (r_acc + w_p[49:0]);
    assign w_rsh  = 36'(w_rsum >>> 14);
    assign w_rsat = (w_rsh[35:31] == 5'b00000 || w_rsh[35:31] == 5'b11111) ? w_rsh[31:0] :
                    (w_rsh[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // cell index: truncate toward zero of (s * cpm + origin * 2^31) / 2^32
    assign w_cv   = 60'($signed(w_p[55:0])) +
                    $signed({18'd0, (r_step == 3'd3) ? r_orow : r_ocol, 31'd0});
    assign w_cmag = w_cv[59] ? 60'(-w_cv) : w_cv;
    assign w_chi  = w_cmag[59:32];
    assign w_cok  = w_cv[59] ? (w_chi == 28'd0) : (32'(w_chi) < pscs_pkg::GRID_SIDE);
    assign w_cidx = w_cv[59] ? '0 : w_chi[AW-1:0];

    // restoring divide of both magnitudes by the sample count
    assign w_rdx = {r_remx, r_mx[32]};
    assign w_rdy = {r_remy, r_my[32]};

    always_comb begin
        w_nqx = 34'(r_sqx) + 34'(r_mx);
        w_nqy = 34'(r_sqy) + 34'(r_my);
        w_nrx = 5'(r_srx) + 5'(r_remx);
        w_nry = 5'(r_sry) + 5'(r_remy);
        if (w_nrx >= 5'(r_nsamp)) begin
            w_nrx = w_nrx - 5'(r_nsamp);
            w_nqx = w_nqx + 34'd1;
        end
        if (w_nry >= 5'(r_nsamp)) begin
            w_nry = w_nry - 5'(r_nsamp);
            w_nqy = w_nqy + 34'd1;
        end
    end

    assign w_cell   = r_cell_ok ? w_rdata : 8'd0;
    assign w_min    = (w_cell < r_run_min) ? w_cell : r_run_min;
    assign w_nfloor = (r_seg < r_floor) ? r_seg : r_floor;
    assign w_csum   = 21'(r_cost) + 21'(w_nfloor);
    assign w_seglen = (r_state == S_SQRT) ? w_sqrt.root : pscs_pkg::LEN_MAX;
    assign w_lsum   = 33'(r_len) + 33'(w_seglen);
    assign w_upd    = !r_best_valid || (r_cost > r_best_cost) ||
                      ((r_cost == r_best_cost) && (r_len < r_best_len));

    assign w_gwe = w_in_acc && (i_operation == pscs_pkg::OP_CELL) &&
                   (32'(i_cell_row) < pscs_pkg::GRID_SIDE) &&
                   (32'(i_cell_col) < pscs_pkg::GRID_SIDE);

    pscs_grid u_grid (
        .i_clk  (i_clk),
        .i_we   (w_gwe),
        .i_waddr({AW'(i_cell_row), AW'(i_cell_col)}),
        .i_wdata(i_cell_value),
        .i_raddr({r_row, r_col}),
        .o_rdata(w_rdata)
    );

    pscs_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_sqrt_start),
        .i_value(r_sq[63:0]),
        .o_stat (w_sqrt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_robot_x    <= '0;
            r_robot_y    <= '0;
            r_cos        <= -16'sd16384;
            r_sin        <= '0;
            r_cpm        <= 24'd5242880;
            r_orow       <= 11'd799;
            r_ocol       <= 11'd799;
            r_nsamp      <= 4'd7;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_floor      <= pscs_pkg::FLOOR_RST;
            r_cost       <= '0;
            r_len        <= '0;
            r_counter    <= '0;
            r_best_cost  <= '0;
            r_best_len   <= '0;
            r_best_idx   <= '0;
            r_best_valid <= 1'b0;
            r_seg        <= '0;
            r_sqrt_start <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_sqrt_start <= 1'b0;
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pscs_pkg::REG_ROBOT_X: r_robot_x <= i_cfg_data;
                    pscs_pkg::REG_ROBOT_Y: r_robot_y <= i_cfg_data;
                    pscs_pkg::REG_ROT_COS: r_cos     <= i_cfg_data[15:0];
                    pscs_pkg::REG_ROT_SIN: r_sin     <= i_cfg_data[15:0];
                    pscs_pkg::REG_CPM:     r_cpm     <= i_cfg_data[23:0];
                    pscs_pkg::REG_ORG_ROW: r_orow    <= i_cfg_data[10:0];
                    pscs_pkg::REG_ORG_COL: r_ocol    <= i_cfg_data[10:0];
                    pscs_pkg::REG_SAMPLES: r_nsamp   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_operation == pscs_pkg::OP_POINT)) begin
                        r_px    <= i_point_x;
                        r_py    <= i_point_y;
                        r_first <= i_path_first;
                        r_last  <= i_path_last;
                        r_batch <= i_batch_last;
                        r_step  <= '0;
                        r_state <= (i_path_last && !i_path_first) ? S_FIN : S_ROT;
                    end
                end
                S_ROT: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1, 3'd3: r_acc <= w_p[49:0];
                        3'd2: r_cx <= w_rsat;
                        3'd4: r_cy <= w_rsat;
                        3'd5: begin
                            r_step <= '0;
                            if (r_first) begin
                                r_prev_x <= r_cx;
                                r_prev_y <= r_cy;
                                r_floor  <= 12'((16'(r_nsamp) + 16'd1) * 16'd255);
                                r_cost   <= '0;
                                r_len    <= '0;
                                r_state  <= r_last ? S_FIN : S_IDLE;
                            end else begin
                                r_dx      <= 33'(r_cx) - 33'(r_prev_x);
                                r_dy      <= 33'(r_cy) - 33'(r_prev_y);
                                r_mx      <= (33'(r_cx) >= 33'(r_prev_x)) ?
                                             33'(33'(r_cx) - 33'(r_prev_x)) :
                                             33'(33'(r_prev_x) - 33'(r_cx));
                                r_my      <= (33'(r_cy) >= 33'(r_prev_y)) ?
                                             33'(33'(r_cy) - 33'(r_prev_y)) :
                                             33'(33'(r_prev_y) - 33'(r_cy));
                                r_remx    <= '0;
                                r_remy    <= '0;
                                r_sqx     <= '0;
                                r_sqy     <= '0;
                                r_srx     <= '0;
                                r_sry     <= '0;
                                r_k       <= '0;
                                r_cnt     <= '0;
                                r_run_min <= 8'd255;
                                r_seg     <= '0;
                                r_state   <= (r_nsamp == 4'd0) ? S_LEN : S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_rdx >= 5'(r_nsamp)) begin
                        r_remx <= 4'(w_rdx - 5'(r_nsamp));
                        r_mx   <= {r_mx[31:0], 1'b1};
                    end else begin
                        r_remx <= w_rdx[3:0];
                        r_mx   <= {r_mx[31:0], 1'b0};
                    end
                    if (w_rdy >= 5'(r_nsamp)) begin
                        r_remy <= 4'(w_rdy - 5'(r_nsamp));
                        r_my   <= {r_my[31:0], 1'b1};
                    end else begin
                        r_remy <= w_rdy[3:0];
                        r_my   <= {r_my[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd32) begin
                        r_step  <= '0;
                        r_state <= S_SAMP;
                    end
                end
                S_SAMP: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: begin
                            r_sqx <= w_nqx[32:0];
                            r_sqy <= w_nqy[32:0];
                            r_srx <= w_nrx[3:0];
                            r_sry <= w_nry[3:0];
                            r_k   <= r_k + 4'd1;
                        end
                        3'd1: begin
                            r_sx <= 32'(34'(r_prev_x) +
                                    (r_dx[32] ? -$signed({1'b0, r_sqx}) : $signed({1'b0, r_sqx})));
                            r_sy <= 32'(34'(r_prev_y) +
                                    (r_dy[32] ? -$signed({1'b0, r_sqy}) : $signed({1'b0, r_sqy})));
                        end
                        3'd3: begin
                            r_row    <= w_cidx;
                            r_row_ok <= w_cok;
                        end
                        3'd4: begin
                            r_col     <= w_cidx;
                            r_cell_ok <= r_row_ok && w_cok;
                        end
                        3'd6: begin
                            r_run_min <= w_min;
                            r_seg     <= r_seg + 12'(w_min);
                            r_step    <= '0;
                            if (r_k == r_nsamp) begin
                                r_state <= S_LEN;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LEN: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: begin
                            r_floor <= w_nfloor;
                            r_cost  <= (w_csum > 21'(pscs_pkg::COST_MAX)) ?
                                       pscs_pkg::COST_MAX : w_csum[19:0];
                        end
                        3'd1: r_sq <= 65'(w_p[63:0]);
                        3'd2: r_sq <= r_sq + 65'(w_p[63:0]);
                        default: begin
                            r_step   <= '0;
                            r_prev_x <= r_cx;
                            r_prev_y <= r_cy;
                            if (r_sq[64]) begin
                                r_len   <= w_lsum[32] ? pscs_pkg::LEN_MAX : w_lsum[31:0];
                                r_state <= S_IDLE;
                            end else begin
                                r_sqrt_start <= 1'b1;
                                r_state      <= S_SQRT;
                            end
                        end
                    endcase
                end
                S_SQRT: begin
                    if (w_sqrt.done) begin
                        r_len   <= w_lsum[32] ? pscs_pkg::LEN_MAX : w_lsum[31:0];
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_idx   <= 7'(r_counter);
                        r_o_cost  <= r_cost;
                        r_o_len   <= r_len;
                        r_o_bidx  <= w_upd ? 7'(r_counter) : 7'(r_best_idx);
                        r_o_bcost <= w_upd ? r_cost : r_best_cost;
                        r_o_blen  <= w_upd ? r_len : r_best_len;
                        r_o_done  <= r_batch;
                        if (r_batch) begin
                            r_counter    <= '0;
                            r_best_valid <= 1'b0;
                            r_best_cost  <= '0;
                            r_best_len   <= '0;
                            r_best_idx   <= '0;
                        end else begin
                            r_counter <= (32'(r_counter) == pscs_pkg::MAX_PATHS - 1) ?
                                         '0 : r_counter + PW'(1);
                            if (w_upd) begin
                                r_best_valid <= 1'b1;
                                r_best_cost  <= r_cost;
                                r_best_len   <= r_len;
                                r_best_idx   <= r_counter;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_path_index  = r_o_idx;
    assign o_path_cost   = r_o_cost;
    assign o_path_length = r_o_len;
    assign o_best_index  = r_o_bidx;
    assign o_best_cost   = r_o_bcost;
    assign o_best_length = r_o_blen;
    assign o_batch_done  = r_o_done;

    a_best_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_bcost >= r_o_cost))
        else $error("best cost below reported path cost");

    a_sqrt_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SQRT) |-> !w_sqrt.busy)
        else $error("square root busy outside its state");

    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg <= pscs_pkg::SEG_MAX))
        else $error("segment cost out of range");

endmodule

// ===== test/score_checker.sv =====
module score_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_operation,
    input  logic [9:0]         i_cell_row,
    input  logic [9:0]         i_cell_col,
    input  logic [7:0]         i_cell_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_path_first,
    input  logic               i_path_last,
    input  logic               i_batch_last,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [6:0]         i_path_index,
    input  logic [19:0]        i_path_cost,
    input  logic [31:0]        i_path_length,
    input  logic [6:0]         i_best_index,
    input  logic [19:0]        i_best_cost,
    input  logic [31:0]        i_best_length,
    input  logic               i_batch_done,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_failures,
    output int                 o_pending
);

    typedef struct packed {
        logic [6:0]  path_index;
        logic [19:0] path_cost;
        logic [31:0] path_length;
        logic [6:0]  best_index;
        logic [19:0] best_cost;
        logic [31:0] best_length;
        logic        batch_done;
    } t_score;

    t_score      score_q[$];
    logic [7:0]  grid_cells[bit [19:0]];

    longint      rob_x, rob_y, cos_q, sin_q, cpm, org_r, org_c, nsamp;
    longint      prev_x, prev_y;
    int unsigned floor_c, cost_acc, path_cnt, best_c, best_i;
    longint unsigned len_acc, best_l;
    bit          best_ok;
    int          fails;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint trunc_cells(longint v);
        if (v >= 0) return v >>> 32;
        return -((-v) >>> 32);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void to_robot(input logic signed [31:0] px, input logic signed [31:0] py,
                                     output longint rx, output longint ry);
        longint tx, ty;
        tx = longint'(px) - rob_x;
        ty = longint'(py) - rob_y;
        rx = clamp32((tx * cos_q - ty * sin_q) >>> 14);
        ry = clamp32((tx * sin_q + ty * cos_q) >>> 14);
    endfunction

    function automatic int unsigned cell_at(longint sx, longint sy);
        longint r, c;
        bit [19:0] key;
        r = trunc_cells(sx * cpm + (org_r <<< 31));
        c = trunc_cells(sy * cpm + (org_c <<< 31));
        if (r < 0 || r >= pscs_pkg::GRID_SIDE || c < 0 || c >= pscs_pkg::GRID_SIDE) return 0;
        key = {r[9:0], c[9:0]};
        if (!grid_cells.exists(key)) return 0;
        return 32'(grid_cells[key]);
    endfunction

    function automatic void add_segment(longint ax, longint ay, longint bx, longint by);
        int unsigned run_min, seg, v;
        longint sx, sy;
        longint unsigned adx, ady, sx2, sy2, len;
        run_min = 255;
        seg = 0;
        for (longint k = 1; k <= nsamp; k++) begin
            sx = ax + ((bx - ax) * k) / nsamp;
            sy = ay + ((by - ay) * k) / nsamp;
            v = cell_at(sx, sy);
            if (v < run_min) run_min = v;
            seg += run_min;
        end
        if (seg < floor_c) floor_c = seg;
        cost_acc += floor_c;
        if (cost_acc > pscs_pkg::COST_MAX) cost_acc = 32'(pscs_pkg::COST_MAX);
        adx = (bx >= ax) ? bx - ax : ax - bx;
        ady = (by >= ay) ? by - ay : ay - by;
        sx2 = adx * adx;
        sy2 = ady * ady;
        if (sx2 > 64'hFFFF_FFFF_FFFF_FFFF - sy2) len = 64'(pscs_pkg::LEN_MAX);
        else len = root64(sx2 + sy2);
        if (len > pscs_pkg::LEN_MAX) len = 64'(pscs_pkg::LEN_MAX);
        len += len_acc;
        len_acc = (len > pscs_pkg::LEN_MAX) ? 64'(pscs_pkg::LEN_MAX) : len;
    endfunction

    function automatic void take_point();
        longint rx, ry;
        t_score s;
        if (i_path_first) begin
            to_robot(i_point_x, i_point_y, rx, ry);
            prev_x = rx;
            prev_y = ry;
            floor_c = 32'(255 * (nsamp + 1));
            cost_acc = 0;
            len_acc = 0;
        end else if (!i_path_last) begin
            to_robot(i_point_x, i_point_y, rx, ry);
            add_segment(prev_x, prev_y, rx, ry);
            prev_x = rx;
            prev_y = ry;
        end
        if (i_path_last) begin
            if (!best_ok || cost_acc > best_c || (cost_acc == best_c && len_acc < best_l)) begin
                best_ok = 1;
                best_c = cost_acc;
                best_l = len_acc;
                best_i = path_cnt;
            end
            s.path_index  = path_cnt[6:0];
            s.path_cost   = cost_acc[19:0];
            s.path_length = len_acc[31:0];
            s.best_index  = best_i[6:0];
            s.best_cost   = best_c[19:0];
            s.best_length = best_l[31:0];
            s.batch_done  = i_batch_last;
            score_q = {score_q, s};
            path_cnt = (path_cnt + 1) % pscs_pkg::MAX_PATHS;
            if (i_batch_last) begin
                path_cnt = 0;
                best_ok = 0;
                best_c = 0;
                best_l = 0;
                best_i = 0;
            end
        end
    endfunction

    initial begin
        fails = 0;
        o_failures = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_score got, want;
        if (!i_rst_n) begin
            rob_x = 0; rob_y = 0; cos_q = -16384; sin_q = 0;
            cpm = 5242880; org_r = 799; org_c = 799; nsamp = 7;
            prev_x = 0; prev_y = 0; floor_c = 2040;
            cost_acc = 0; len_acc = 0; path_cnt = 0;
            best_c = 0; best_l = 0; best_i = 0; best_ok = 0;
            score_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pscs_pkg::REG_ROBOT_X: rob_x = longint'($signed(i_cfg_data));
                    pscs_pkg::REG_ROBOT_Y: rob_y = longint'($signed(i_cfg_data));
                    pscs_pkg::REG_ROT_COS: cos_q = longint'($signed(i_cfg_data[15:0]));
                    pscs_pkg::REG_ROT_SIN: sin_q = longint'($signed(i_cfg_data[15:0]));
                    pscs_pkg::REG_CPM:     cpm = longint'(i_cfg_data[23:0]);
                    pscs_pkg::REG_ORG_ROW: org_r = longint'(i_cfg_data[10:0]);
                    pscs_pkg::REG_ORG_COL: org_c = longint'(i_cfg_data[10:0]);
                    pscs_pkg::REG_SAMPLES: nsamp = longint'(i_cfg_data[3:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_path_index, i_path_cost, i_path_length, i_best_index,
                       i_best_cost, i_best_length, i_batch_done};
                if (score_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %p", got);
                end else begin
                    want = score_q.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == pscs_pkg::OP_CELL)
                    grid_cells[{i_cell_row, i_cell_col}] = i_cell_value;
                else take_point();
            end
        end
        o_failures <= fails;
        o_pending <= score_q.size();
    end

endmodule

// ===== test/path_set_cost_scorer_test.sv =====
module path_set_cost_scorer_test;

    localparam int ITEMS      = 1900;
    localparam int QUIET_TAIL = 200;
    localparam int SETTLE     = 300;
    localparam int LIMIT      = 4000000;

    typedef enum {PH_WINDOW, PH_FINE, PH_WILD, PH_EDGE} t_phase;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic [9:0]         i_cell_row;
    logic [9:0]         i_cell_col;
    logic [7:0]         i_cell_value;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic               i_path_first;
    logic               i_path_last;
    logic               i_batch_last;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [6:0]         o_path_index;
    logic [19:0]        o_path_cost;
    logic [31:0]        o_path_length;
    logic [6:0]         o_best_index;
    logic [19:0]        o_best_cost;
    logic [31:0]        o_best_length;
    logic               o_batch_done;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    int                 failures, pending, cycles, items;
    bit                 quiet;
    t_phase             kind;
    logic signed [31:0] base_x, base_y;
    int unsigned        spread;

    path_set_cost_scorer dut (.*);

    score_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_operation,
        .i_cell_row, .i_cell_col, .i_cell_value, .i_point_x, .i_point_y,
        .i_path_first, .i_path_last, .i_batch_last,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_path_index(o_path_index), .i_path_cost(o_path_cost),
        .i_path_length(o_path_length), .i_best_index(o_best_index),
        .i_best_cost(o_best_cost), .i_best_length(o_best_length),
        .i_batch_done(o_batch_done), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_failures(failures), .o_pending(pending)
    );

    initial i_clk = 0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_out_ready = 1;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_ready <= 1;
            end
        end
    end

    task automatic pause(int n);
        i_in_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_req(logic op, logic [9:0] r, logic [9:0] c, logic [7:0] v,
                            logic [31:0] px, logic [31:0] py, logic f, logic l, logic b);
        i_in_valid   <= 1;
        i_operation  <= op;
        i_cell_row   <= r;
        i_cell_col   <= c;
        i_cell_value <= v;
        i_point_x    <= px;
        i_point_y    <= py;
        i_path_first <= f;
        i_path_last  <= l;
        i_batch_last <= b;
        do @(posedge i_clk); while (!o_in_ready);
        items++;
        if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
    endtask

    task automatic send_cell(logic [9:0] r, logic [9:0] c, logic [7:0] v);
        send_req(pscs_pkg::OP_CELL, r, c, v, $urandom, $urandom,
                 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic f, logic l, logic b);
        send_req(pscs_pkg::OP_POINT, 10'($urandom), 10'($urandom), 8'($urandom),
                 px, py, f, l, b);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base, int unsigned half);
        int off;
        off = int'($urandom_range(0, 2 * half)) - int'(half);
        return base + off;
    endfunction

    // keeps every sample inside written cells or off the grid
    task automatic make_point(output logic [31:0] px, output logic [31:0] py);
        case (kind)
            PH_WILD: begin
                px = $urandom;
                py = $urandom;
            end
            PH_EDGE: begin
                px = $urandom_range(0, 983040);
                py = near(0, 983040);
            end
            default: begin
                px = near(base_x, spread);
                py = near(base_y, spread);
            end
        endcase
    endtask

    task automatic wait_idle();
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_we    <= 1;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_phase(t_phase k, logic [3:0] ns);
        logic signed [15:0] c, s;
        logic [23:0]        cpm;
        logic [10:0]        orr, orc;
        logic [31:0]        px, py;
        wait_idle();
        kind = k;
        case ($urandom_range(0, 3))
            0: begin c = 16'sd16384; s = 16'sd0; end
            1: begin c = -16'sd16384; s = 16'sd0; end
            2: begin c = 16'sd0; s = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384; end
            default: begin
                c = 16'(int'($urandom_range(0, 32768)) - 16384);
                s = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
        endcase
        base_x = near(0, 65536000);
        base_y = near(0, 65536000);
        case (k)
            PH_WINDOW: begin
                spread = 458752;
                cpm = $urandom_range(0, 1) ? 24'd65536 : 24'($urandom_range(0, 65536));
                orr = $urandom_range(0, 1) ? 11'd32 : 11'd0;
                orc = $urandom_range(0, 1) ? 11'd32 : 11'd0;
            end
            PH_FINE: begin
                spread = 1966;
                cpm = 24'hFFFFFF;
                orr = 11'd32;
                orc = 11'd32;
            end
            PH_WILD: begin
                base_x = $urandom;
                base_y = $urandom;
                cpm = 24'd0;
                orr = 11'($urandom_range(0, 2047));
                orc = 11'($urandom_range(0, 2047));
            end
            default: begin
                base_x = 0;
                base_y = 0;
                c = 16'sd16384;
                s = 16'sd0;
                cpm = 24'd65536;
                orr = 11'd2047;
                orc = 11'd32;
            end
        endcase
        write_reg(pscs_pkg::REG_ROBOT_X, base_x);
        write_reg(pscs_pkg::REG_ROBOT_Y, base_y);
        write_reg(pscs_pkg::REG_ROT_COS, {{16{c[15]}}, c});
        write_reg(pscs_pkg::REG_ROT_SIN, {{16{s[15]}}, s});
        write_reg(pscs_pkg::REG_CPM, {8'd0, cpm});
        write_reg(pscs_pkg::REG_ORG_ROW, {21'd0, orr});
        write_reg(pscs_pkg::REG_ORG_COL, {21'd0, orc});
        write_reg(pscs_pkg::REG_SAMPLES, {28'd0, ns});
        if (k == PH_WILD) send_cell(orr[10:1], orc[10:1], 8'($urandom));
        // new frame: restart the previous point
        make_point(px, py);
        send_point(px, py, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic send_path();
        logic [31:0] px, py;
        make_point(px, py);
        send_point(px, py, 1'b1, 1'b0, 1'($urandom));
        repeat ($urandom_range(0, 5)) begin
            make_point(px, py);
            send_point(px, py, 1'b0, 1'b0, 1'($urandom));
        end
        make_point(px, py);
        send_point(px, py, 1'b0, 1'b1, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int next_phase, pick;
        logic [31:0] px, py;
        cycles = 0;
        items = 0;
        quiet = 0;
        kind = PH_WINDOW;
        i_rst_n = 0;
        i_in_valid = 0;
        i_operation = pscs_pkg::OP_CELL;
        i_cell_row = 0;
        i_cell_col = 0;
        i_cell_value = 0;
        i_point_x = 0;
        i_point_y = 0;
        i_path_first = 0;
        i_path_last = 0;
        i_batch_last = 0;
        i_cfg_we = 0;
        i_cfg_index = pscs_pkg::REG_ROBOT_X;
        i_cfg_data = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++) send_cell(10'(r), 10'(c), 8'($urandom));
        for (int c = 0; c < 32; c++) send_cell(10'd1023, 10'(c), 8'($urandom));
        send_cell(10'd1023, 10'd1023, 8'd0);
        send_cell(10'd0, 10'd0, 8'd255);

        set_phase(PH_WILD, 4'd15);
        send_point(32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b0);
        send_point(32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1);
        send_point(32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        send_point(32'hFFFFFFFF, 32'h1, 1'b0, 1'b1, 1'b0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 1'b0);
        send_point(32'h0, 32'h0, 1'b0, 1'b1, 1'b1);
        send_point(32'h80000000, 32'h80000000, 1'b0, 1'b0, 1'b0);
        send_point(32'h0, 32'h0, 1'b0, 1'b1, 1'b0);
        set_phase(PH_WINDOW, 4'd0);
        make_point(px, py); send_point(px, py, 1'b0, 1'b0, 1'b0);
        make_point(px, py); send_point(px, py, 1'b0, 1'b1, 1'b1);
        set_phase(PH_EDGE, 4'd1);
        make_point(px, py); send_point(px, py, 1'b0, 1'b0, 1'b0);
        make_point(px, py); send_point(px, py, 1'b0, 1'b0, 1'b0);
        send_point(32'h0, 32'h0, 1'b0, 1'b1, 1'b1);
        set_phase(PH_FINE, 4'd15);
        make_point(px, py); send_point(px, py, 1'b0, 1'b0, 1'b0);
        send_point(32'h0, 32'h0, 1'b0, 1'b1, 1'b0);

        next_phase = items;
        while (items < ITEMS) begin
            quiet = items >= ITEMS - QUIET_TAIL;
            if (items >= next_phase) begin
                pick = $urandom_range(0, 4);
                set_phase(pick < 2 ? PH_WINDOW : t_phase'(pick - 1), 4'($urandom_range(0, 15)));
                next_phase = items + $urandom_range(80, 160);
            end
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                if ($urandom_range(0, 9) < 7)
                    send_cell($urandom_range(0, 1) ? 10'd1023 : 10'($urandom_range(0, 31)),
                              10'($urandom_range(0, 31)), 8'($urandom));
                else
                    send_cell(10'($urandom), 10'($urandom), 8'($urandom));
            end else if (pick < 5) begin
                make_point(px, py);
                send_point(px, py, 1'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_path();
            end
        end

        wait_idle();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/pscs_pkg.sv
design/pscs_mult.sv
design/pscs_isqrt.sv
design/pscs_grid.sv
design/path_set_cost_scorer.sv
test/score_checker.sv
test/path_set_cost_scorer_test.sv
